// ----- design/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants of the linear probe id map.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CmdW  = 2;

  // hash mixer constants
  localparam logic [31:0] HashMul   = 32'h7feb352d;
  localparam int unsigned HashShA   = 16;
  localparam int unsigned HashShB   = 15;

  typedef enum logic [CmdW-1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

endpackage

// ----- design/lpm_if.sv -----
// ----------------------------------------------------------------------------
// lpm_req_if / lpm_rsp_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface lpm_req_if;
  logic                      valid;
  logic                      ready;
  logic [lpm_pkg::CmdW-1:0]  command;
  logic [lpm_pkg::KeyW-1:0]  key;
  logic [lpm_pkg::ValW-1:0]  value_in;

  modport source (output valid, command, key, value_in, input ready);
  modport sink   (input valid, command, key, value_in, output ready);
endinterface

interface lpm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lpm_pkg::ValW-1:0]  value_out;
  logic                      status;

  modport source (output valid, hit, value_out, status, input ready);
  modport sink   (input valid, hit, value_out, status, output ready);
endinterface

// ----- design/linear_probe_id_map.sv -----
// ----------------------------------------------------------------------------
// linear_probe_id_map
// Hash map of 32-bit keys to 32-bit values, linear probing, fixed capacity.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command beat (find, insert/update, clear); rsp_o returns
//   exactly one result beat per command, in order.
//   Path: 2 hash stages and a registered queue, then the probe engine. The slot
//   table and key store are memories with a separate write port and registered
//   reads, so each occupied slot checked takes a slot read, a key read and a
//   compare, and the empty slot that ends a miss takes only the slot read and
//   its check.
//   Clear walks every stored entry (read used-slot list, zero slot).
//   Concurrency: one command in flight in the probe engine; the front keeps
//   hashing and a 2-beat queue absorbs commands meanwhile.
//   Reset: the slot table is swept to empty with req_i ready held low; entry
//   count returns to zero.
//   Backpressure: the next command is not started until the output register
//   is free, so a stalled receiver backs up into the queue and req_i.ready.
// ----------------------------------------------------------------------------
module linear_probe_id_map #(
  parameter int unsigned SLOT_COUNT  = 1024,
  parameter int unsigned MAX_ENTRIES = 716
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpm_req_if.sink   req_i,
  lpm_rsp_if.source rsp_o
);

  localparam int unsigned SlotBits = $clog2(SLOT_COUNT);
  localparam int unsigned DataW    = lpm_pkg::CmdW + lpm_pkg::KeyW + lpm_pkg::ValW + SlotBits;
  localparam int unsigned QDepth   = 2;

  logic             push, push_ready, pop, pop_valid, init_busy;
  logic [DataW-1:0] push_data, pop_data;

  // hashing front end; held off during the reset sweep of the slot table
  lpm_front #(.SlotBits(SlotBits), .DataW(DataW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (!init_busy),
    .req_i        (req_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lpm_queue #(.DataW(DataW), .Depth(QDepth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  // probe engine owns all table state
  lpm_back #(
    .SlotCount  (SLOT_COUNT),
    .MaxEntries (MAX_ENTRIES),
    .SlotBits   (SlotBits),
    .DataW      (DataW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_busy_o (init_busy),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- design/lpm_front.sv -----
// ----------------------------------------------------------------------------
// lpm_front
// Accepts command beats and computes the home slot in two stages.
// ----------------------------------------------------------------------------
module lpm_front #(
  parameter int unsigned SlotBits = 10,
  parameter int unsigned DataW    = lpm_pkg::CmdW + lpm_pkg::KeyW + lpm_pkg::ValW + SlotBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,       // low during table init sweep
  lpm_req_if.sink          req_i,
  output logic             push_o,
  input  logic             push_ready_i,
  output logic [DataW-1:0] push_data_o
);

  logic                        s1_valid_q, s2_valid_q;
  logic [lpm_pkg::CmdW-1:0]    s1_cmd_q, s2_cmd_q;
  logic [lpm_pkg::KeyW-1:0]    s1_key_q, s2_key_q;
  logic [lpm_pkg::ValW-1:0]    s1_val_q, s2_val_q;
  logic [31:0]                 s1_mix_q, s2_prod_q;
  logic [31:0]                 mix_d, prod_d, fold;
  logic                        s2_adv, s1_adv, take;

  assign s2_adv = s2_valid_q && push_ready_i;
  assign s1_adv = s1_valid_q && (!s2_valid_q || s2_adv);
  assign req_i.ready = en_i && (!s1_valid_q || s1_adv);
  assign take = req_i.valid && req_i.ready;

  assign mix_d  = req_i.key ^ (req_i.key >> lpm_pkg::HashShA);
  assign prod_d = 32'(s1_mix_q * lpm_pkg::HashMul);   // low word is all the mask needs
  assign fold   = s2_prod_q ^ (s2_prod_q >> lpm_pkg::HashShB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (take) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) s2_valid_q <= 1'b1;
      else if (s2_adv) s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cmd_q <= req_i.command;
      s1_key_q <= req_i.key;
      s1_val_q <= req_i.value_in;
      s1_mix_q <= mix_d;
    end
    if (s1_adv) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_key_q  <= s1_key_q;
      s2_val_q  <= s1_val_q;
      s2_prod_q <= prod_d;
    end
  end

  assign push_o      = s2_valid_q;
  assign push_data_o = {s2_cmd_q, s2_key_q, s2_val_q, fold[SlotBits-1:0]};

endmodule

// ----- design/lpm_queue.sv -----
// ----------------------------------------------------------------------------
// lpm_queue
// Short FIFO between the hashing front and the probing back.
// ----------------------------------------------------------------------------
module lpm_queue #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [DataW-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [DataW-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             wr, rd;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign wr = push_i && push_ready_o;
  assign rd = pop_i && pop_valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (rd) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- design/lpm_back.sv -----
// ----------------------------------------------------------------------------
// lpm_back
// Probe engine: slot table, dense stores, clear sweep and result register.
// ----------------------------------------------------------------------------
module lpm_back #(
  parameter int unsigned SlotCount  = 1024,
  parameter int unsigned MaxEntries = 716,
  parameter int unsigned SlotBits   = $clog2(SlotCount),
  parameter int unsigned DataW      = lpm_pkg::CmdW + lpm_pkg::KeyW + lpm_pkg::ValW + SlotBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             init_busy_o,
  input  logic             pop_valid_i,
  output logic             pop_o,
  input  logic [DataW-1:0] pop_data_i,
  lpm_rsp_if.source        rsp_o
);

  localparam int unsigned IdxW = $clog2(MaxEntries + 1);  // tags and count
  localparam int unsigned EaW  = $clog2(MaxEntries);      // store address

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_RD_SLOT, ST_CHK_SLOT, ST_CHK_KEY, ST_CLR_RD, ST_CLR_WR
  } state_e;

  state_e                   state_q;
  logic [SlotBits-1:0]      init_idx_q, slot_q, probe_q;
  logic [IdxW-1:0]          cnt_q, clr_idx_q;
  logic [lpm_pkg::CmdW-1:0] cmd_q;
  logic [lpm_pkg::KeyW-1:0] key_q;
  logic [lpm_pkg::ValW-1:0] val_q;

  logic                     out_valid_q, hit_q, status_q;
  logic [lpm_pkg::ValW-1:0] vout_q;

  // memories
  logic [IdxW-1:0]          slot_mem [SlotCount];
  logic [lpm_pkg::KeyW-1:0] key_mem  [MaxEntries];
  logic [lpm_pkg::ValW-1:0] val_mem  [MaxEntries];
  logic [SlotBits-1:0]      used_mem [MaxEntries];
  logic [IdxW-1:0]          slot_rd_q;
  logic [lpm_pkg::KeyW-1:0] key_rd_q;
  logic [lpm_pkg::ValW-1:0] val_rd_q;
  logic [SlotBits-1:0]      used_rd_q;

  logic                     slot_we, new_we, val_we;
  logic [SlotBits-1:0]      slot_wa;
  logic [IdxW-1:0]          slot_wd;
  logic [EaW-1:0]           val_wa, ent_ra;
  logic [IdxW-1:0]          ent_full;
  logic                     ent_ok, key_eq, out_free, last_probe, full;
  logic                     imm_done;
  lpm_pkg::cmd_e            pop_cmd;

  assign ent_full   = slot_rd_q - 1'b1;
  assign ent_ra     = ent_full[EaW-1:0];
  assign ent_ok     = (slot_rd_q != '0) && (ent_full < cnt_q);
  assign key_eq     = ent_ok && (key_rd_q == key_q);
  assign last_probe = (probe_q == SlotBits'(SlotCount - 1));
  assign full       = (cnt_q >= IdxW'(MaxEntries));
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign pop_o      = (state_q == ST_IDLE) && pop_valid_i && out_free;
  assign pop_cmd    = lpm_pkg::cmd_e'(pop_data_i[DataW-1 -: lpm_pkg::CmdW]);
  assign init_busy_o = (state_q == ST_INIT);

  // popped beat answered right away (empty clear, unused code)
  assign imm_done = pop_o && !(pop_cmd inside {lpm_pkg::CMD_FIND, lpm_pkg::CMD_INSERT})
                    && !(pop_cmd == lpm_pkg::CMD_CLEAR && cnt_q != '0);

  // write port selection
  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot_q;
    slot_wd = '0;
    new_we  = 1'b0;
    val_we  = 1'b0;
    val_wa  = cnt_q[EaW-1:0];
    case (state_q)
      ST_INIT: begin
        slot_we = 1'b1;
        slot_wa = init_idx_q;
      end
      ST_CHK_SLOT: begin
        if (slot_rd_q == '0 && cmd_q == lpm_pkg::CMD_INSERT && !full) begin
          slot_we = 1'b1;
          slot_wd = cnt_q + 1'b1;
          new_we  = 1'b1;
          val_we  = 1'b1;
        end
      end
      ST_CHK_KEY: begin
        if (key_eq && cmd_q == lpm_pkg::CMD_INSERT) begin
          val_we = 1'b1;
          val_wa = ent_ra;
        end
      end
      ST_CLR_WR: begin
        slot_we = 1'b1;
        slot_wa = used_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_q <= slot_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (new_we) key_mem[cnt_q[EaW-1:0]] <= key_q;
    key_rd_q <= key_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_q;
    val_rd_q <= val_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (new_we) used_mem[cnt_q[EaW-1:0]] <= slot_q;
    used_rd_q <= used_mem[clr_idx_q[EaW-1:0]];
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_idx_q  <= '0;
      cnt_q       <= '0;
      clr_idx_q   <= '0;
      probe_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      status_q    <= 1'b0;
      vout_q      <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready && !imm_done) out_valid_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          init_idx_q <= init_idx_q + 1'b1;
          if (init_idx_q == SlotBits'(SlotCount - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pop_o) begin
            probe_q   <= '0;
            clr_idx_q <= '0;
            case (pop_cmd)
              lpm_pkg::CMD_FIND, lpm_pkg::CMD_INSERT: state_q <= ST_RD_SLOT;
              lpm_pkg::CMD_CLEAR: begin
                if (cnt_q == '0) begin
                  out_valid_q <= 1'b1;
                  {hit_q, status_q, vout_q} <= '0;
                end else begin
                  state_q <= ST_CLR_RD;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
                {hit_q, status_q, vout_q} <= '0;
              end
            endcase
          end
        end
        ST_RD_SLOT: state_q <= ST_CHK_SLOT;
        ST_CHK_SLOT: begin
          if (slot_rd_q == '0) begin
            out_valid_q <= 1'b1;
            {hit_q, vout_q} <= '0;
            status_q <= (cmd_q == lpm_pkg::CMD_INSERT) && full;
            if (new_we) cnt_q <= cnt_q + 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_CHK_KEY;
          end
        end
        ST_CHK_KEY: begin
          if (key_eq) begin
            out_valid_q <= 1'b1;
            hit_q    <= 1'b1;
            status_q <= 1'b0;
            vout_q   <= (cmd_q == lpm_pkg::CMD_FIND) ? val_rd_q : '0;
            state_q  <= ST_IDLE;
          end else if (last_probe) begin
            // wrapped the whole table without an empty slot
            out_valid_q <= 1'b1;
            {hit_q, vout_q} <= '0;
            status_q <= (cmd_q == lpm_pkg::CMD_INSERT);
            state_q  <= ST_IDLE;
          end else begin
            probe_q <= probe_q + 1'b1;
            state_q <= ST_RD_SLOT;
          end
        end
        ST_CLR_RD: state_q <= ST_CLR_WR;
        ST_CLR_WR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q + 1'b1 == cnt_q) begin
            cnt_q       <= '0;
            out_valid_q <= 1'b1;
            {hit_q, status_q, vout_q} <= '0;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_CLR_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // item latch and probe walk
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= pop_data_i[DataW-1 -: lpm_pkg::CmdW];
      key_q  <= pop_data_i[DataW-lpm_pkg::CmdW-1 -: lpm_pkg::KeyW];
      val_q  <= pop_data_i[SlotBits +: lpm_pkg::ValW];
      slot_q <= pop_data_i[SlotBits-1:0];
    end else if (state_q == ST_CHK_KEY && !key_eq) begin
      slot_q <= slot_q + 1'b1;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = hit_q;
  assign rsp_o.value_out = vout_q;
  assign rsp_o.status    = status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IdxW'(MaxEntries)) else $error("entry count above capacity");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE && out_free) else $error("pop while busy");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR_WR && clr_idx_q + 1'b1 == cnt_q) |=> cnt_q == '0 && out_valid_q)
    else $error("clear did not finish");

  a_no_pop_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy_o |-> !pop_o && !out_valid_q) else $error("activity during init");

endmodule
